// File: src/tgt_pkg.sv
// tempo grid tick generator: shared types, codes and constants
// no dependencies

package tgt_pkg;

  localparam int unsigned NUM_MODES = 30;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned IVAL_W    = 16;
  localparam int unsigned MODE_W    = 5;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = NUM_MODES;

  localparam logic [IVAL_W-1:0] DEFAULT_TEMPO = 16'd500;
  localparam logic [MODE_W-1:0] BYPASS_A_RST  = 5'd2;
  localparam logic [MODE_W-1:0] BYPASS_B_RST  = 5'd6;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = 5;

  // item kinds on the input
  localparam logic [KIND_W-1:0] KIND_UPDATE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TAP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TEMPO   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPMODE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SYNC    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_B   = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_UPDATE,
    OP_TAP,
    OP_TEMPO,
    OP_MODE,
    OP_SYNC,
    OP_RESTART
  } op_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_EXEC,
    BS_DIV,
    BS_FIN
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] now;
    logic [IVAL_W-1:0] ival;
    logic [TIME_W-1:0] evt;   // raw event time for tap, resolved start time otherwise
    logic              ext;
    logic [MODE_W-1:0] nmode;
    logic              calc;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // event time zero or in the future means now
  function automatic logic [TIME_W-1:0] pick_t0(input logic [TIME_W-1:0] ev,
                                                input logic [TIME_W-1:0] now);
    pick_t0 = ((ev == '0) || (ev > now)) ? now : ev;
  endfunction

endpackage

// File: src/tgt_front.sv
// front end: accepts items, classifies them and queues them for the back end
// depends on tgt_pkg

module tgt_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tgt_pkg::KIND_W-1:0] in_mode,
  input  logic [tgt_pkg::TIME_W-1:0] in_now_ms,
  input  logic [tgt_pkg::IVAL_W-1:0] in_interval_ms,
  input  logic [tgt_pkg::TIME_W-1:0] in_event_time_ms,
  input  logic                       in_external_clock,
  input  logic [tgt_pkg::MODE_W-1:0] in_new_op_mode,
  input  logic                       in_calc_change,
  input  logic                       pop,
  output logic                       q_valid,
  output tgt_pkg::item_t             q_item
);

  tgt_pkg::item_t                 dec_item;
  tgt_pkg::item_t                 q_r [tgt_pkg::QDEPTH];
  logic [tgt_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tgt_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tgt_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           push;

  // classify: ignored requests become no-ops here
  always_comb begin
    dec_item.now   = in_now_ms;
    dec_item.ival  = in_interval_ms;
    dec_item.ext   = in_external_clock;
    dec_item.nmode = in_new_op_mode;
    dec_item.calc  = in_calc_change;
    case (in_mode)
      tgt_pkg::KIND_UPDATE:  dec_item.op = tgt_pkg::OP_UPDATE;
      tgt_pkg::KIND_TAP:
        dec_item.op = (in_interval_ms != '0) ? tgt_pkg::OP_TAP : tgt_pkg::OP_NONE;
      tgt_pkg::KIND_TEMPO:
        dec_item.op = (in_interval_ms != '0) ? tgt_pkg::OP_TEMPO : tgt_pkg::OP_NONE;
      tgt_pkg::KIND_OPMODE:
        dec_item.op = (in_new_op_mode < tgt_pkg::MODE_W'(tgt_pkg::NUM_MODES)) ?
                      tgt_pkg::OP_MODE : tgt_pkg::OP_NONE;
      tgt_pkg::KIND_SYNC:    dec_item.op = tgt_pkg::OP_SYNC;
      tgt_pkg::KIND_RESTART: dec_item.op = tgt_pkg::OP_RESTART;
      default:               dec_item.op = tgt_pkg::OP_NONE;
    endcase
    dec_item.evt = (dec_item.op == tgt_pkg::OP_TAP) ? in_event_time_ms :
                   tgt_pkg::pick_t0(in_event_time_ms, in_now_ms);
  end

  assign in_ready = (cnt_r != tgt_pkg::QCNT_W'(tgt_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tgt_pkg::QCNT_W'(tgt_pkg::QDEPTH))
    else $error("queue count over depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

// File: src/tgt_div.sv
// iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// depends on tgt_pkg

module tgt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tgt_pkg::TIME_W-1:0] dividend,
  input  logic [tgt_pkg::IVAL_W-1:0] divisor,
  output tgt_pkg::div_stat_t         stat,
  output logic [tgt_pkg::TIME_W-1:0] quo,
  output logic [tgt_pkg::IVAL_W-1:0] rem
);

  logic [tgt_pkg::TIME_W-1:0]    quo_r, quo_nxt;
  logic [tgt_pkg::IVAL_W-1:0]    rem_r, rem_nxt;
  logic [tgt_pkg::IVAL_W-1:0]    dvs_r;
  logic [tgt_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [tgt_pkg::IVAL_W:0]      trial;
  logic [tgt_pkg::IVAL_W:0]      diff;

  always_comb begin
    trial = {rem_r, quo_r[tgt_pkg::TIME_W-1]};
    diff  = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[tgt_pkg::IVAL_W-1:0];
      quo_nxt = {quo_r[tgt_pkg::TIME_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[tgt_pkg::IVAL_W-1:0];
      quo_nxt = {quo_r[tgt_pkg::TIME_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= tgt_pkg::DIV_CNT_W'(tgt_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule

// File: src/tgt_back.sv
// back end: beat grid state, item execution, configuration and result register
// depends on tgt_pkg and tgt_div

module tgt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  tgt_pkg::item_t                q_item,
  output logic                          pop,
  input  logic                          cfg_wr_en,
  input  logic [tgt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgt_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tick,
  output logic                          out_pulse_out,
  output logic [tgt_pkg::TIME_W-1:0]    out_tick_count,
  output logic [tgt_pkg::IVAL_W-1:0]    out_tempo_ms,
  output logic [tgt_pkg::TIME_W-1:0]    out_elapsed_ms,
  output logic                          out_sync_flag,
  output logic                          out_calc_changed_flag,
  output logic                          out_run_mode_step,
  output logic [tgt_pkg::MODE_W-1:0]    out_op_mode
);

  tgt_pkg::back_state_t state_r, state_nxt;
  tgt_pkg::item_t       cur_r;
  tgt_pkg::div_stat_t   div_st;

  logic [tgt_pkg::CFG_W-1:0]  mask_r;
  logic [tgt_pkg::MODE_W-1:0] byp_a_r, byp_b_r;

  logic [tgt_pkg::TIME_W-1:0] last_beat_r, last_beat_nxt;
  logic [tgt_pkg::TIME_W-1:0] last_upd_r, last_upd_nxt;
  logic [tgt_pkg::TIME_W-1:0] count_r, count_nxt;
  logic [tgt_pkg::IVAL_W-1:0] period_r, period_nxt;
  logic [tgt_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                       tap_pend_r, tap_pend_nxt;
  logic [tgt_pkg::IVAL_W-1:0] tap_per_r, tap_per_nxt;
  logic [tgt_pkg::TIME_W-1:0] tap_time_r, tap_time_nxt;
  logic                       sync_r, sync_nxt;
  logic                       calc_r, calc_nxt;
  logic                       byp_r, byp_nxt;

  logic                       res_tick, res_pulse, res_sync, res_calc, res_run;
  logic [tgt_pkg::TIME_W-1:0] res_elapsed;
  logic [31:0]                mask_ext;

  logic                       out_valid_r;
  logic                       slot_free;
  logic [tgt_pkg::TIME_W-1:0] late;
  logic                       due;
  logic                       needs_div;
  logic                       div_start;
  logic                       commit;
  logic [tgt_pkg::TIME_W-1:0] div_dividend;
  logic [tgt_pkg::IVAL_W-1:0] div_divisor;
  logic [tgt_pkg::TIME_W-1:0] div_quo;
  logic [tgt_pkg::IVAL_W-1:0] div_rem;

  assign slot_free = !out_valid_r || out_ready;
  assign late      = cur_r.now - last_beat_r;
  assign due       = (period_r != '0) && (late >= {16'b0, period_r});
  assign needs_div = ((cur_r.op == tgt_pkg::OP_UPDATE) && !tap_pend_r && due) ||
                     ((cur_r.op == tgt_pkg::OP_TEMPO) && cur_r.ext);

  always_comb begin
    if (cur_r.op == tgt_pkg::OP_UPDATE) begin
      div_dividend = late;
      div_divisor  = period_r;
    end else begin
      div_dividend = cur_r.now - cur_r.evt;
      div_divisor  = cur_r.ival;
    end
  end

  tgt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_st),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgt_pkg::BS_IDLE: if (q_valid) state_nxt = tgt_pkg::BS_EXEC;
      tgt_pkg::BS_EXEC: begin
        if (needs_div) begin
          state_nxt = tgt_pkg::BS_DIV;
        end else if (slot_free) begin
          state_nxt = tgt_pkg::BS_IDLE;
        end
      end
      tgt_pkg::BS_DIV:  if (div_st.done) state_nxt = tgt_pkg::BS_FIN;
      tgt_pkg::BS_FIN:  if (slot_free) state_nxt = tgt_pkg::BS_IDLE;
      default:          state_nxt = tgt_pkg::BS_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state_r)
      tgt_pkg::BS_IDLE: pop = q_valid;
      tgt_pkg::BS_EXEC: begin
        div_start = needs_div;
        commit    = !needs_div && slot_free;
      end
      tgt_pkg::BS_FIN:  commit = slot_free;
      default: ;
    endcase
  end

  // item execution
  always_comb begin
    last_beat_nxt = last_beat_r;
    last_upd_nxt  = last_upd_r;
    count_nxt     = count_r;
    period_nxt    = period_r;
    mode_nxt      = mode_r;
    tap_pend_nxt  = tap_pend_r;
    tap_per_nxt   = tap_per_r;
    tap_time_nxt  = tap_time_r;
    sync_nxt      = sync_r;
    calc_nxt      = calc_r;
    byp_nxt       = byp_r;
    res_tick      = 1'b0;
    res_pulse     = 1'b0;
    res_sync      = 1'b0;
    res_calc      = 1'b0;
    res_run       = 1'b0;
    res_elapsed   = '0;
    mask_ext      = 32'(mask_r);
    case (cur_r.op)
      tgt_pkg::OP_UPDATE: begin
        res_elapsed = cur_r.now - last_upd_r;
        if (tap_pend_r) begin
          tap_pend_nxt  = 1'b0;
          period_nxt    = tap_per_r;
          last_beat_nxt = tgt_pkg::pick_t0(tap_time_r, cur_r.now);
          count_nxt     = count_r + 1'b1;
          res_tick      = 1'b1;
        end else if (due) begin
          // catch up by whole periods: grid lands at now minus remainder
          last_beat_nxt = cur_r.now - {16'b0, div_rem};
          count_nxt     = count_r + div_quo;
          res_tick      = 1'b1;
        end
        res_pulse    = res_tick && !mask_ext[mode_r];
        res_sync     = sync_r;
        res_calc     = calc_r;
        res_run      = !byp_r;
        byp_nxt      = 1'b0;
        sync_nxt     = 1'b0;
        calc_nxt     = 1'b0;
        last_upd_nxt = cur_r.now;
      end
      tgt_pkg::OP_TAP: begin
        tap_pend_nxt = 1'b1;
        tap_per_nxt  = cur_r.ival;
        tap_time_nxt = cur_r.evt;
      end
      tgt_pkg::OP_TEMPO: begin
        period_nxt    = cur_r.ival;
        last_beat_nxt = cur_r.ext ? cur_r.now - {16'b0, div_rem} : cur_r.evt;
      end
      tgt_pkg::OP_MODE: begin
        if (cur_r.nmode != mode_r) begin
          mode_nxt  = cur_r.nmode;
          count_nxt = '0;
          byp_nxt   = (cur_r.nmode == byp_a_r) || (cur_r.nmode == byp_b_r);
        end
      end
      tgt_pkg::OP_SYNC: begin
        sync_nxt  = 1'b1;
        calc_nxt  = cur_r.calc;
        count_nxt = '0;
      end
      tgt_pkg::OP_RESTART: begin
        last_beat_nxt = cur_r.now;
        count_nxt     = '0;
        sync_nxt      = 1'b1;
        calc_nxt      = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tgt_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      byp_a_r     <= tgt_pkg::BYPASS_A_RST;
      byp_b_r     <= tgt_pkg::BYPASS_B_RST;
      last_beat_r <= '0;
      last_upd_r  <= '0;
      count_r     <= '0;
      period_r    <= tgt_pkg::DEFAULT_TEMPO;
      mode_r      <= '0;
      tap_pend_r  <= 1'b0;
      tap_per_r   <= '0;
      tap_time_r  <= '0;
      sync_r      <= 1'b0;
      calc_r      <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          tgt_pkg::REG_PULSE_MASK: mask_r  <= cfg_wdata;
          tgt_pkg::REG_BYPASS_A:   byp_a_r <= cfg_wdata[tgt_pkg::MODE_W-1:0];
          tgt_pkg::REG_BYPASS_B:   byp_b_r <= cfg_wdata[tgt_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        last_beat_r <= last_beat_nxt;
        last_upd_r  <= last_upd_nxt;
        count_r     <= count_nxt;
        period_r    <= period_nxt;
        mode_r      <= mode_nxt;
        tap_pend_r  <= tap_pend_nxt;
        tap_per_r   <= tap_per_nxt;
        tap_time_r  <= tap_time_nxt;
        sync_r      <= sync_nxt;
        calc_r      <= calc_nxt;
        byp_r       <= byp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_item;
    end
    if (commit) begin
      out_tick              <= res_tick;
      out_pulse_out         <= res_pulse;
      out_tick_count        <= count_nxt;
      out_tempo_ms          <= period_nxt;
      out_elapsed_ms        <= res_elapsed;
      out_sync_flag         <= res_sync;
      out_calc_changed_flag <= res_calc;
      out_run_mode_step     <= res_run;
      out_op_mode           <= mode_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgt_pkg::BS_DIV) |-> (div_st.busy || div_st.done))
    else $error("divider idle while waiting on it");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == tgt_pkg::BS_DIV))
    else $error("divider finished outside divide state");

  a_tap_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgt_pkg::BS_EXEC && cur_r.op == tgt_pkg::OP_UPDATE && tap_pend_r)
      |-> !needs_div)
    else $error("tap boundary update started a divide");
`endif

endmodule

// File: src/tempo_grid_tick_generator_top.sv
// an accepted item is written into the queue, popped into the back end's item register and
// executed; a catch-up or grid snap first runs the bit-serial divider before the commit
// the back end takes a new item only after committing the last one; the queue accepts input while not full
// a 2-item queue decouples the input from execution; the result register frees the back end
// reset: synchronous active-low rst_n clears queue, state and flags, tempo to 500 ms,
// pulse mask to 0 and bypass modes to 2 and 6; no clearing pass

module tempo_grid_tick_generator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tgt_pkg::KIND_W-1:0]    in_mode,
  input  logic [tgt_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [tgt_pkg::IVAL_W-1:0]    in_interval_ms,
  input  logic [tgt_pkg::TIME_W-1:0]    in_event_time_ms,
  input  logic                          in_external_clock,
  input  logic [tgt_pkg::MODE_W-1:0]    in_new_op_mode,
  input  logic                          in_calc_change,
  input  logic                          cfg_wr_en,
  input  logic [tgt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgt_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tick,
  output logic                          out_pulse_out,
  output logic [tgt_pkg::TIME_W-1:0]    out_tick_count,
  output logic [tgt_pkg::IVAL_W-1:0]    out_tempo_ms,
  output logic [tgt_pkg::TIME_W-1:0]    out_elapsed_ms,
  output logic                          out_sync_flag,
  output logic                          out_calc_changed_flag,
  output logic                          out_run_mode_step,
  output logic [tgt_pkg::MODE_W-1:0]    out_op_mode
);

  logic           q_valid;
  logic           pop;
  tgt_pkg::item_t q_item;

  tgt_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_now_ms         (in_now_ms),
    .in_interval_ms    (in_interval_ms),
    .in_event_time_ms  (in_event_time_ms),
    .in_external_clock (in_external_clock),
    .in_new_op_mode    (in_new_op_mode),
    .in_calc_change    (in_calc_change),
    .pop               (pop),
    .q_valid           (q_valid),
    .q_item            (q_item)
  );

  tgt_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .pop                   (pop),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_tick              (out_tick),
    .out_pulse_out         (out_pulse_out),
    .out_tick_count        (out_tick_count),
    .out_tempo_ms          (out_tempo_ms),
    .out_elapsed_ms        (out_elapsed_ms),
    .out_sync_flag         (out_sync_flag),
    .out_calc_changed_flag (out_calc_changed_flag),
    .out_run_mode_step     (out_run_mode_step),
    .out_op_mode           (out_op_mode)
  );

endmodule

// File: bench/tempo_grid_tick_generator_top_tb.sv
// testbench for tempo_grid_tick_generator_top: directed table, then random items in six blocks
// checked field by field against a beat grid predictor; depends on tgt_pkg and the rtl top

module tempo_grid_tick_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tgt_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [tgt_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int unsigned BLOCK_ITEMS = 75;
  localparam int unsigned HOLD_AFTER = 420;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [tgt_pkg::KIND_W-1:0] kind;
    logic [tgt_pkg::TIME_W-1:0] now;
    logic [tgt_pkg::IVAL_W-1:0] ival;
    logic [tgt_pkg::TIME_W-1:0] ev;
    logic                       ext;
    logic [tgt_pkg::MODE_W-1:0] nmode;
    logic                       calc;
  } beat_req_t;

  typedef struct packed {
    logic                       tick;
    logic                       pulse;
    logic [tgt_pkg::TIME_W-1:0] count;
    logic [tgt_pkg::IVAL_W-1:0] tempo;
    logic [tgt_pkg::TIME_W-1:0] elapsed;
    logic                       sync;
    logic                       calc;
    logic                       run;
    logic [tgt_pkg::MODE_W-1:0] op;
  } beat_rep_t;

  typedef struct packed {
    beat_req_t req;
    logic      typed;
    beat_rep_t rep;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [tgt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tgt_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic out_tick, out_pulse_out, out_sync_flag, out_calc_changed_flag, out_run_mode_step;
  logic [tgt_pkg::TIME_W-1:0] out_tick_count, out_elapsed_ms;
  logic [tgt_pkg::IVAL_W-1:0] out_tempo_ms;
  logic [tgt_pkg::MODE_W-1:0] out_op_mode;

  beat_req_t cur_req = '0;
  logic cur_typed = 1'b0;
  beat_rep_t cur_rep = '0;

  // predictor state and register copies
  logic [tgt_pkg::TIME_W-1:0] g_last_beat, g_last_upd, g_count, tap_at;
  logic [tgt_pkg::IVAL_W-1:0] g_period, tap_len;
  logic [tgt_pkg::MODE_W-1:0] g_mode, byp_a, byp_b;
  logic [tgt_pkg::CFG_W-1:0] g_mask;
  logic tap_armed, sync_due, calc_due, skip_step;

  beat_rep_t beat_reports_due[$];
  plan_row_t plan[$];
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit long_hold_done = 1'b0;
  logic [tgt_pkg::TIME_W-1:0] sim_ms = '0;
  logic [tgt_pkg::TIME_W-1:0] stim_span = 32'd500;

  tempo_grid_tick_generator_top uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (cur_req.kind),
    .in_now_ms             (cur_req.now),
    .in_interval_ms        (cur_req.ival),
    .in_event_time_ms      (cur_req.ev),
    .in_external_clock     (cur_req.ext),
    .in_new_op_mode        (cur_req.nmode),
    .in_calc_change        (cur_req.calc),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_tick              (out_tick),
    .out_pulse_out         (out_pulse_out),
    .out_tick_count        (out_tick_count),
    .out_tempo_ms          (out_tempo_ms),
    .out_elapsed_ms        (out_elapsed_ms),
    .out_sync_flag         (out_sync_flag),
    .out_calc_changed_flag (out_calc_changed_flag),
    .out_run_mode_step     (out_run_mode_step),
    .out_op_mode           (out_op_mode)
  );

  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  initial begin
    #2_000_000;
    $display("tempo_grid_tick_generator_top_tb: FAIL");
    $finish;
  end

  function automatic logic [tgt_pkg::TIME_W-1:0] start_of(logic [tgt_pkg::TIME_W-1:0] ev,
                                                           logic [tgt_pkg::TIME_W-1:0] now);
    return (ev == '0 || ev > now) ? now : ev;
  endfunction

  function automatic beat_rep_t advance_grid(beat_req_t r);
    beat_rep_t o;
    logic [tgt_pkg::TIME_W-1:0] late, n, t0;
    o = '0;
    case (r.kind)
      tgt_pkg::KIND_UPDATE: begin
        o.elapsed = r.now - g_last_upd;
        if (tap_armed) begin
          tap_armed = 1'b0;
          g_period = tap_len;
          g_last_beat = start_of(tap_at, r.now);
          g_count = g_count + 1;
          o.tick = 1'b1;
        end else if (g_period != '0 && (r.now - g_last_beat) >= {16'd0, g_period}) begin
          late = r.now - g_last_beat;
          n = late / {16'd0, g_period};
          g_last_beat = g_last_beat + n * {16'd0, g_period};
          g_count = g_count + n;
          o.tick = 1'b1;
        end
        if (o.tick) begin
          o.pulse = (g_mode >= tgt_pkg::NUM_MODES) || !g_mask[g_mode];
        end
        o.sync = sync_due;
        o.calc = calc_due;
        o.run = !skip_step;
        skip_step = 1'b0;
        sync_due = 1'b0;
        calc_due = 1'b0;
        g_last_upd = r.now;
      end
      tgt_pkg::KIND_TAP: begin
        if (r.ival != '0) begin
          tap_armed = 1'b1;
          tap_len = r.ival;
          tap_at = r.ev;
        end
      end
      tgt_pkg::KIND_TEMPO: begin
        if (r.ival != '0) begin
          t0 = start_of(r.ev, r.now);
          g_period = r.ival;
          if (!r.ext) begin
            g_last_beat = t0;
          end else begin
            g_last_beat = t0 + ((r.now - t0) / {16'd0, r.ival}) * {16'd0, r.ival};
          end
        end
      end
      tgt_pkg::KIND_OPMODE: begin
        if (r.nmode != g_mode && r.nmode < tgt_pkg::NUM_MODES) begin
          g_mode = r.nmode;
          g_count = '0;
          skip_step = (r.nmode == byp_a) || (r.nmode == byp_b);
        end
      end
      tgt_pkg::KIND_SYNC: begin
        sync_due = 1'b1;
        calc_due = r.calc;
        g_count = '0;
      end
      tgt_pkg::KIND_RESTART: begin
        g_last_beat = r.now;
        g_count = '0;
        sync_due = 1'b1;
        calc_due = 1'b0;
      end
      default: begin
      end
    endcase
    o.count = g_count;
    o.tempo = g_period;
    o.op = g_mode;
    return o;
  endfunction

  function automatic beat_req_t req(logic [tgt_pkg::KIND_W-1:0] kind,
                                    logic [tgt_pkg::TIME_W-1:0] now,
                                    logic [tgt_pkg::IVAL_W-1:0] ival,
                                    logic [tgt_pkg::TIME_W-1:0] ev,
                                    logic ext, logic [tgt_pkg::MODE_W-1:0] nmode,
                                    logic calc);
    beat_req_t r;
    r.kind = kind;
    r.now = now;
    r.ival = ival;
    r.ev = ev;
    r.ext = ext;
    r.nmode = nmode;
    r.calc = calc;
    return r;
  endfunction

  function automatic beat_rep_t rep(logic tick, logic pulse, logic [tgt_pkg::TIME_W-1:0] count,
                                    logic [tgt_pkg::TIME_W-1:0] elapsed);
    beat_rep_t o;
    o = '0;
    o.tick = tick;
    o.pulse = pulse;
    o.count = count;
    o.tempo = tgt_pkg::DEFAULT_TEMPO;
    o.elapsed = elapsed;
    o.run = 1'b1;
    return o;
  endfunction

  function automatic plan_row_t row(beat_req_t r, logic typed, beat_rep_t e);
    plan_row_t p;
    p.req = r;
    p.typed = typed;
    p.rep = e;
    return p;
  endfunction

  function automatic beat_req_t random_req();
    beat_req_t r;
    int unsigned k, s, v, e, m;
    k = $urandom_range(99);
    s = $urandom_range(99);
    v = $urandom_range(99);
    e = $urandom_range(99);
    m = $urandom_range(99);
    if (k < 55) r.kind = tgt_pkg::KIND_UPDATE;
    else if (k < 63) r.kind = tgt_pkg::KIND_TAP;
    else if (k < 73) r.kind = tgt_pkg::KIND_TEMPO;
    else if (k < 82) r.kind = tgt_pkg::KIND_OPMODE;
    else if (k < 88) r.kind = tgt_pkg::KIND_SYNC;
    else if (k < 94) r.kind = tgt_pkg::KIND_RESTART;
    else if (k < 97) r.kind = KIND_SPARE6;
    else r.kind = KIND_SPARE7;
    if (s < 80) sim_ms = sim_ms + $urandom_range(0, 2 * stim_span);
    else if (s < 90) sim_ms = sim_ms + $urandom_range(0, 20);
    else if (s < 95) sim_ms = $urandom();
    else sim_ms = sim_ms - $urandom_range(0, 1000);
    r.now = sim_ms;
    if (v < 10) r.ival = '0;
    else if (v < 20) r.ival = 16'($urandom_range(0, 65535));
    else r.ival = 16'($urandom_range(1, 300));
    if ((r.kind == tgt_pkg::KIND_TAP || r.kind == tgt_pkg::KIND_TEMPO) && r.ival != '0) begin
      stim_span = (r.ival > 16'd3000) ? 32'd3000 : {16'd0, r.ival};
    end
    if (e < 25) r.ev = '0;
    else if (e < 75) r.ev = r.now - $urandom_range(0, 3 * stim_span);
    else if (e < 90) r.ev = $urandom();
    else r.ev = r.now + $urandom_range(1, 1000);
    r.ext = 1'($urandom_range(1));
    r.calc = 1'($urandom_range(1));
    if (m < 15) r.nmode = byp_a;
    else if (m < 30) r.nmode = byp_b;
    else if (m < 85) r.nmode = 5'($urandom_range(0, tgt_pkg::NUM_MODES - 1));
    else r.nmode = 5'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic check_field(string name, logic [tgt_pkg::TIME_W-1:0] want,
                             logic [tgt_pkg::TIME_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    beat_rep_t e;
    beat_rep_t p;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        reports_seen++;
        if (beat_reports_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item, tick_count %0d", $time, out_tick_count);
        end else begin
          e = beat_reports_due.pop_front();
          check_field("tick", 32'(e.tick), 32'(out_tick));
          check_field("pulse_out", 32'(e.pulse), 32'(out_pulse_out));
          check_field("tick_count", e.count, out_tick_count);
          check_field("tempo_ms", 32'(e.tempo), 32'(out_tempo_ms));
          check_field("elapsed_ms", e.elapsed, out_elapsed_ms);
          check_field("sync_flag", 32'(e.sync), 32'(out_sync_flag));
          check_field("calc_changed_flag", 32'(e.calc), 32'(out_calc_changed_flag));
          check_field("run_mode_step", 32'(e.run), 32'(out_run_mode_step));
          check_field("op_mode", 32'(e.op), 32'(out_op_mode));
        end
      end
      if (in_valid && in_ready) begin
        p = advance_grid(cur_req);
        beat_reports_due.push_back(cur_typed ? cur_rep : p);
      end
    end
  end

  // receiver, with one long hold-off once the run is well underway
  initial begin
    forever begin
      @(negedge clk);
      if (!long_hold_done && reports_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(beat_req_t r, logic typed, beat_rep_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cur_req <= r;
    cur_typed <= typed;
    cur_rep <= e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (beat_reports_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [tgt_pkg::CFG_IDX_W-1:0] idx,
                           logic [tgt_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tgt_pkg::REG_PULSE_MASK: g_mask = val;
      tgt_pkg::REG_BYPASS_A: byp_a = val[tgt_pkg::MODE_W-1:0];
      tgt_pkg::REG_BYPASS_B: byp_b = val[tgt_pkg::MODE_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [tgt_pkg::CFG_W-1:0] mask, logic [tgt_pkg::MODE_W-1:0] a,
                          logic [tgt_pkg::MODE_W-1:0] b);
    write_reg(tgt_pkg::REG_PULSE_MASK, mask);
    write_reg(tgt_pkg::REG_BYPASS_A, {25'd0, a});
    write_reg(tgt_pkg::REG_BYPASS_B, {25'd0, b});
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    g_last_beat = '0;
    g_last_upd = '0;
    g_count = '0;
    g_period = tgt_pkg::DEFAULT_TEMPO;
    g_mode = '0;
    tap_armed = 1'b0;
    tap_len = '0;
    tap_at = '0;
    sync_due = 1'b0;
    calc_due = 1'b0;
    skip_step = 1'b0;
    g_mask = '0;
    byp_a = tgt_pkg::BYPASS_A_RST;
    byp_b = tgt_pkg::BYPASS_B_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd0, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b1, rep(1'b0, 1'b0, 32'd0, 32'd0)));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd499, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b1, rep(1'b0, 1'b0, 32'd0, 32'd499)));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd500, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b1, rep(1'b1, 1'b1, 32'd1, 32'd1)));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd2600, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b1, rep(1'b1, 1'b1, 32'd5, 32'd2100)));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0, 5'd0,
                           1'b0), 1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_TEMPO, 32'd100, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_TEMPO, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b1, 5'd0,
                           1'b0), 1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_TEMPO, 32'd1000, 16'd7, 32'd301, 1'b1, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_TEMPO, 32'd1000, 16'd3, 32'd5000, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd1010, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_TAP, 32'd1020, 16'd0, 32'd1015, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_TAP, 32'd1020, 16'd1, 32'd1015, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd1030, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_TAP, 32'd1040, 16'd40, 32'd9999, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd1050, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_OPMODE, 32'd1060, 16'd0, 32'd0, 1'b0, 5'd2, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_OPMODE, 32'd1070, 16'd0, 32'd0, 1'b0, 5'd2, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_OPMODE, 32'd1080, 16'd0, 32'd0, 1'b0, 5'd31, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd1100, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_SYNC, 32'd1100, 16'd0, 32'd0, 1'b0, 5'd0, 1'b1),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd1150, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_RESTART, 32'd1200, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_UPDATE, 32'd1200, 16'd0, 32'd0, 1'b0, 5'd0, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(tgt_pkg::KIND_OPMODE, 32'd1210, 16'd0, 32'd0, 1'b0, 5'd29, 1'b0),
                       1'b0, '0));
    plan.push_back(row(req(KIND_SPARE6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 5'd31,
                           1'b1), 1'b0, '0));
    plan.push_back(row(req(KIND_SPARE7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 5'd31,
                           1'b1), 1'b0, '0));

    send_idle_pct = 11;
    recv_idle_pct = 74;
    foreach (plan[i]) begin
      send_item(plan[i].req, plan[i].typed, plan[i].rep);
    end
    drain();
    sim_ms = 32'd1300;

    for (int blk = 0; blk < 6; blk++) begin
      if (blk < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 74;
      end else if (blk < 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (blk)
        0: set_regs('0, 5'd0, 5'd29);
        1: set_regs(30'h3FFF_FFFF, 5'd29, 5'd0);
        2: set_regs(30'($urandom()), 5'd31, 5'd30);
        3: set_regs(30'($urandom()), 5'($urandom_range(0, 29)), 5'($urandom_range(0, 29)));
        4: set_regs(30'h2AAA_AAAA, 5'd2, 5'd6);
        default: set_regs(30'($urandom()), 5'($urandom_range(0, 31)), 5'd31);
      endcase
      repeat (BLOCK_ITEMS) begin
        send_item(random_req(), 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tempo_grid_tick_generator_top_tb: PASS");
    end else begin
      $display("tempo_grid_tick_generator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
